// ----- rtl/pes_pkg.sv -----
package pes_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] MODE_NUM = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_MUL = 3'd3;
  localparam logic [2:0] MODE_DIV = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_LEFT  = 3'd4;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] token_value;
    logic                     last_token;
  } pes_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [2:0]               status;
  } pes_out_t;

  // per-cell command: load from the head port, or shift one place
  typedef struct packed {
    logic load;
    logic shift_dn;
    logic shift_up;
  } pes_cell_cmd_t;

endpackage

// ----- rtl/pes_cell.sv -----
module pes_cell (
  input  logic                        clk,
  input  pes_pkg::pes_cell_cmd_t      cmd,
  input  logic [pes_pkg::DATA_W-1:0]  load_data,
  input  logic [pes_pkg::DATA_W-1:0]  from_above,
  input  logic [pes_pkg::DATA_W-1:0]  from_below,
  output logic [pes_pkg::DATA_W-1:0]  q
);
  import pes_pkg::*;

  logic [DATA_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= load_data;
    end else if (cmd.shift_dn) begin
      q_r <= from_above;
    end else if (cmd.shift_up) begin
      q_r <= from_below;
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/pes_div.sv -----
module pes_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pes_pkg::DATA_W-1:0]  dividend,
  input  logic [pes_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [pes_pkg::DATA_W-1:0]  quotient
);
  import pes_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] mb_r;
  logic              neg_r;
  logic [DATA_W-1:0] q_r;

  logic              na, nb;
  logic [DATA_W-1:0] ma, mb;
  logic [DATA_W:0]   trial;
  logic [DATA_W+1:0] diff;
  logic              qbit;
  logic [DATA_W-1:0] quo_nxt;

  always_comb begin
    na      = dividend[DATA_W-1];
    nb      = divisor[DATA_W-1];
    ma      = na ? (DATA_W'(0) - dividend) : dividend;
    mb      = nb ? (DATA_W'(0) - divisor) : divisor;
    trial   = {rem_r, quo_r[DATA_W-1]};
    diff    = {1'b0, trial} - {2'b00, mb_r};
    qbit    = ~diff[DATA_W+1];
    quo_nxt = {quo_r[DATA_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DATA_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring step: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= ma;
      mb_r  <= mb;
      neg_r <= na ^ nb;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= quo_nxt;
      if (cnt_r == '0) begin
        q_r <= neg_r ? (DATA_W'(0) - quo_nxt) : quo_nxt;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/prefix_expression_stack_evaluator.sv -----
// Prefix expression evaluator with an operand stack built as a chain of cells.
// Input channel in_valid / in_data / in_stall carries one token a beat, in
// right-to-left order: a number or one of + - * /. Numbers are pushed; an
// operator takes the top as left operand and the next as right operand.
// The stack top is cell 0; a push shifts every cell down one place, an
// operator writes its result into cell 0 and shifts the rest up.
// Each token is accepted in S_IDLE and then executed in S_EXEC. A divide
// then waits in S_DIV on the bit-serial divider (one bit a cycle over 32
// bits). A last token goes on to S_FIN to load the result register, which
// happens once the output slot is free.
// Output channel out_valid / out_data / out_stall gives one beat per
// expression: value and status (underflow, overflow, divide by zero,
// leftover operands); the first error sticks until the last token.
// While out_stall holds a result, non-last tokens keep being accepted; the
// next last token waits until the held beat is taken.
// Reset empties the stack and clears the error; no clearing pass is needed.
module prefix_expression_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pes_pkg::pes_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output pes_pkg::pes_out_t out_data,
  input  logic              out_stall
);
  import pes_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  pes_in_t          tok_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  pes_out_t         out_r, out_nxt;

  logic              push, pop, div_start, div_done, fin_go;
  logic [DATA_W-1:0] op_res, div_q;
  logic [DATA_W-1:0] left_v, right_v;
  logic [DATA_W-1:0] cell_q [STACK_DEPTH];

  assign left_v  = cell_q[0];
  assign right_v = cell_q[1];

  // operand stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    pes_cell_cmd_t     cmd;
    logic [DATA_W-1:0] above, below;
    if (i == 0) begin : g_head
      assign cmd   = '{load: push | pop, shift_dn: 1'b0, shift_up: 1'b0};
      assign above = '0;
    end else begin : g_body
      assign cmd   = '{load: 1'b0, shift_dn: push, shift_up: pop};
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_mid
      assign below = cell_q[i+1];
    end
    pes_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_data  (push ? DATA_W'(tok_r.token_value) : op_res),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i])
    );
  end

  pes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (left_v),
    .divisor  (right_v),
    .done     (div_done),
    .quotient (div_q)
  );

  assign fin_go = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    push          = 1'b0;
    pop           = 1'b0;
    div_start     = 1'b0;
    op_res        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = tok_r.last_token ? S_FIN : S_IDLE;
        if (err_r == ST_OK) begin
          case (tok_r.mode) inside
            MODE_NUM: begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                err_nxt = ST_OVER;
              end else begin
                push    = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              if (cnt_r < CNT_W'(2)) begin
                err_nxt = ST_UNDER;
              end else if (tok_r.mode == MODE_DIV) begin
                if (right_v == '0) begin
                  err_nxt = ST_DIVZ;
                end else begin
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end
              end else begin
                pop     = 1'b1;
                cnt_nxt = cnt_r - 1'b1;
                case (tok_r.mode)
                  MODE_ADD: op_res = left_v + right_v;
                  MODE_SUB: op_res = left_v - right_v;
                  default:  op_res = left_v * right_v;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          pop       = 1'b1;
          op_res    = div_q;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = tok_r.last_token ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            out_nxt = '{result_value: '0, status: err_r};
          end else if (cnt_r == CNT_W'(1)) begin
            out_nxt = '{result_value: left_v, status: ST_OK};
          end else begin
            out_nxt = '{result_value: '0, status: ST_LEFT};
          end
          cnt_nxt   = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold the token and the result beat
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      tok_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> tok_r.mode == MODE_DIV)
    else $error("divider running for a non-divide token");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.result_value == '0)
    else $error("non-zero value with error status");

  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> cnt_r == '0 && err_r == ST_OK)
    else $error("stack not emptied after last token");

endmodule
